// ----- src/glyph_pixel_stream_generator_assert.svh -----
// Assertion macros used by the glyph pixel stream generator RTL.
`ifndef GLYPH_PIXEL_STREAM_GENERATOR_ASSERT_SVH
`define GLYPH_PIXEL_STREAM_GENERATOR_ASSERT_SVH

// same-cycle implication
`define GPSG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPSG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gpsg_pkg.sv -----
// Types and constants shared by the glyph pixel stream generator.
package gpsg_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 7;

  localparam int COORD_W  = 10;
  localparam int CURSOR_W = 11;
  localparam int COLOR_W  = 16;
  localparam int CNT_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(GLYPH_WIDTH - 1);
  localparam logic [CNT_W-1:0] ROW_LAST = CNT_W'(GLYPH_HEIGHT - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

  localparam logic [COLOR_W-1:0] FG_COLOR_RST      = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST      = 16'h0000;
  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 10'd320;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 10'd240;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [COORD_W-1:0] screen_width;
    logic [COORD_W-1:0] screen_height;
  } cfg_t;

  // glyph[c][r]: column c, row r
  typedef logic [GLYPH_WIDTH-1:0][GLYPH_HEIGHT-1:0] glyph_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GLYPH,
    ST_GAP,
    ST_SKIP,
    ST_ADV
  } state_t;

endpackage

// ----- src/gpsg_seq.sv -----
// Glyph sequencer: cursor, shared coordinate adders and the pixel output register.
`include "glyph_pixel_stream_generator_assert.svh"

module gpsg_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gpsg_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_line,
  input  logic [gpsg_pkg::COORD_W-1:0]  in_start_x,
  input  logic [gpsg_pkg::COORD_W-1:0]  in_start_y,
  input  gpsg_pkg::glyph_t              in_glyph,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gpsg_pkg::COORD_W-1:0]  out_pixel_x,
  output logic [gpsg_pkg::COORD_W-1:0]  out_pixel_y,
  output logic [gpsg_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_pixel_valid,
  output logic                          out_last
);
  import gpsg_pkg::*;

  state_t state_r, state_nxt;

  logic [CURSOR_W-1:0] cursor_col_r, cursor_col_nxt;
  logic [COORD_W-1:0]  cursor_row_r, cursor_row_nxt;
  glyph_t              glyph_r, glyph_nxt;
  logic [CNT_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic                gap_r, gap_nxt;
  logic                adv_r, adv_nxt;

  logic                out_valid_r;
  logic [COORD_W-1:0]  out_pixel_x_r;
  logic [COORD_W-1:0]  out_pixel_y_r;
  logic [COLOR_W-1:0]  out_pixel_color_r;
  logic                out_pixel_valid_r;
  logic                out_last_r;

  // shared adders: operand picked by state
  logic [CURSOR_W-1:0] col_off, col_sum;
  logic [CURSOR_W-1:0] row_off, row_sum;
  logic [CURSOR_W-1:0] width_ext, height_ext;

  logic                fire;
  logic                emit;
  logic [COORD_W-1:0]  emit_x, emit_y;
  logic [COLOR_W-1:0]  emit_color;
  logic                emit_pv, emit_last;
  logic                off_screen, overrun;

  assign fire       = !out_valid_r || !out_stall;
  assign width_ext  = {1'b0, cfg.screen_width};
  assign height_ext = {1'b0, cfg.screen_height};
  assign col_sum    = cursor_col_r + col_off;
  assign row_sum    = {1'b0, cursor_row_r} + row_off;

  assign off_screen = cursor_col_r >= width_ext;
  assign overrun    = (col_sum > width_ext) || (row_sum > height_ext);

  // next state and datapath state
  always_comb begin
    state_nxt      = state_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    glyph_nxt      = glyph_r;
    col_cnt_nxt    = col_cnt_r;
    row_cnt_nxt    = row_cnt_r;
    gap_nxt        = gap_r;
    adv_nxt        = adv_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_start_line) begin
            cursor_col_nxt = {1'b0, in_start_x};
            cursor_row_nxt = in_start_y;
          end
          glyph_nxt = in_glyph;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
        gap_nxt     = col_sum < width_ext;
        adv_nxt     = !off_screen;
        state_nxt   = (off_screen || overrun) ? ST_SKIP : ST_GLYPH;
      end
      ST_GLYPH: begin
        if (fire) begin
          if (col_cnt_r == COL_LAST) begin
            col_cnt_nxt = '0;
            if (row_cnt_r == ROW_LAST) begin
              row_cnt_nxt = '0;
              state_nxt   = gap_r ? ST_GAP : ST_ADV;
            end else begin
              row_cnt_nxt = row_cnt_r + 1'b1;
            end
          end else begin
            col_cnt_nxt = col_cnt_r + 1'b1;
          end
        end
      end
      ST_GAP: begin
        if (fire) begin
          if (row_cnt_r == ROW_LAST) begin
            row_cnt_nxt = '0;
            state_nxt   = ST_ADV;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end
      end
      ST_SKIP: begin
        if (fire) state_nxt = adv_r ? ST_ADV : ST_IDLE;
      end
      ST_ADV: begin
        cursor_col_nxt = col_sum;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: adder operands, handshake and the result to load
  always_comb begin
    in_stall   = 1'b1;
    col_off    = CURSOR_W'(GLYPH_WIDTH);
    row_off    = '0;
    emit       = 1'b0;
    emit_x     = '0;
    emit_y     = '0;
    emit_color = '0;
    emit_pv    = 1'b0;
    emit_last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_CHECK: begin
        col_off = CURSOR_W'(GLYPH_WIDTH);
        row_off = CURSOR_W'(GLYPH_HEIGHT);
      end
      ST_GLYPH: begin
        col_off    = {{(CURSOR_W-CNT_W){1'b0}}, col_cnt_r};
        row_off    = {{(CURSOR_W-CNT_W){1'b0}}, row_cnt_r};
        emit       = 1'b1;
        emit_x     = col_sum[COORD_W-1:0];
        emit_y     = row_sum[COORD_W-1:0];
        emit_color = glyph_r[col_cnt_r][row_cnt_r] ? cfg.fg_color : cfg.bg_color;
        emit_pv    = 1'b1;
        emit_last  = !gap_r && (col_cnt_r == COL_LAST) && (row_cnt_r == ROW_LAST);
      end
      ST_GAP: begin
        col_off    = CURSOR_W'(GLYPH_WIDTH);
        row_off    = {{(CURSOR_W-CNT_W){1'b0}}, row_cnt_r};
        emit       = 1'b1;
        emit_x     = col_sum[COORD_W-1:0];
        emit_y     = row_sum[COORD_W-1:0];
        emit_color = cfg.bg_color;
        emit_pv    = 1'b1;
        emit_last  = row_cnt_r == ROW_LAST;
      end
      ST_SKIP: begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      ST_ADV: begin
        col_off = CURSOR_W'(GLYPH_WIDTH + 1);
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      gap_r        <= 1'b0;
      adv_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      col_cnt_r    <= col_cnt_nxt;
      row_cnt_r    <= row_cnt_nxt;
      gap_r        <= gap_nxt;
      adv_r        <= adv_nxt;
      if (fire) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    if (fire && emit) begin
      out_pixel_x_r     <= emit_x;
      out_pixel_y_r     <= emit_y;
      out_pixel_color_r <= emit_color;
      out_pixel_valid_r <= emit_pv;
      out_last_r        <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_pixel_color = out_pixel_color_r;
  assign out_pixel_valid = out_pixel_valid_r;
  assign out_last        = out_last_r;

  `GPSG_ASSERT_IMP(a_skip_is_last, clk, rst_n, out_valid_r && !out_pixel_valid_r,
                   out_last_r, "skipped glyph result without last")
  `GPSG_ASSERT_NXT(a_accept_to_check, clk, rst_n, in_valid && !in_stall,
                   state_r == ST_CHECK, "accepted request did not enter check")
  `GPSG_ASSERT_NXT(a_cursor_hold, clk, rst_n, state_r == ST_GLYPH || state_r == ST_GAP,
                   $stable(cursor_col_r) && $stable(cursor_row_r), "cursor moved mid glyph")
  `GPSG_ASSERT_NXT(a_last_ends_item, clk, rst_n, fire && emit && emit_last,
                   state_r == ST_ADV || state_r == ST_IDLE, "sequencer kept going after last")

endmodule

// ----- src/glyph_pixel_stream_generator.sv -----
// Top level of the glyph pixel stream generator: configuration registers and sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in_     | input     | in_valid / in_stall  | start_line, start_x, start_y, glyph_col0..4
//  out_    | output    | out_valid / out_stall| pixel_x, pixel_y, pixel_color, pixel_valid, last
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A drawn glyph: take the request, check the edges, send 35 glyph pixels plus 7 gap
// pixels if the gap column fits, at one per cycle while out_stall is low, step the cursor.
// A skipped glyph sends one result, pixel_valid low and last set. The single coordinate
// adder pair and the output register pace the work; out_stall holds the emitting states.
// Synchronous reset loads the register defaults and puts the cursor at 0,0.
module glyph_pixel_stream_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_start_line,
  input  logic [gpsg_pkg::COORD_W-1:0]    in_start_x,
  input  logic [gpsg_pkg::COORD_W-1:0]    in_start_y,
  input  logic [gpsg_pkg::GLYPH_HEIGHT-1:0] in_glyph_col0,
  input  logic [gpsg_pkg::GLYPH_HEIGHT-1:0] in_glyph_col1,
  input  logic [gpsg_pkg::GLYPH_HEIGHT-1:0] in_glyph_col2,
  input  logic [gpsg_pkg::GLYPH_HEIGHT-1:0] in_glyph_col3,
  input  logic [gpsg_pkg::GLYPH_HEIGHT-1:0] in_glyph_col4,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gpsg_pkg::COORD_W-1:0]    out_pixel_x,
  output logic [gpsg_pkg::COORD_W-1:0]    out_pixel_y,
  output logic [gpsg_pkg::COLOR_W-1:0]    out_pixel_color,
  output logic                            out_pixel_valid,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gpsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpsg_pkg::COLOR_W-1:0]    cfg_data
);
  import gpsg_pkg::*;

  cfg_t   cfg_r;
  glyph_t glyph_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_color      <= FG_COLOR_RST;
      cfg_r.bg_color      <= BG_COLOR_RST;
      cfg_r.screen_width  <= SCREEN_WIDTH_RST;
      cfg_r.screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FG_COLOR:      cfg_r.fg_color      <= cfg_data;
        CFG_BG_COLOR:      cfg_r.bg_color      <= cfg_data;
        CFG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data[COORD_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign glyph_in = {in_glyph_col4, in_glyph_col3, in_glyph_col2, in_glyph_col1, in_glyph_col0};

  gpsg_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_line   (in_start_line),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_glyph        (glyph_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_valid (out_pixel_valid),
    .out_last        (out_last)
  );

endmodule
